// ----- src/utf8_code_point_decoder_assert.svh -----
// assertion helpers shared by the decoder modules
`ifndef UTF8_CODE_POINT_DECODER_ASSERT_SVH
`define UTF8_CODE_POINT_DECODER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define UTF8D_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define UTF8D_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- src/utf8d_pkg.sv -----
package utf8d_pkg;

   // counter width inside the block; outputs carry the low OUT_CNT_W bits
   localparam int CNT_W     = 16;
   localparam int OUT_CNT_W = 16;
   localparam int CNT_EXT_W = (CNT_W > OUT_CNT_W) ? CNT_W : OUT_CNT_W;
   localparam int CP_W      = 21;
   localparam int LEN_W     = 3;
   localparam int PEND_W    = 2;

   localparam logic [7:0] LEAD2_MASK = 8'h1f;
   localparam logic [7:0] LEAD3_MASK = 8'h0f;
   localparam logic [7:0] LEAD4_MASK = 8'h07;
   localparam logic [7:0] CONT_MASK  = 8'h3f;

   localparam logic [LEN_W-1:0] LEN_ONE   = LEN_W'(1);
   localparam logic [LEN_W-1:0] LEN_TWO   = LEN_W'(2);
   localparam logic [LEN_W-1:0] LEN_THREE = LEN_W'(3);
   localparam logic [LEN_W-1:0] LEN_FOUR  = LEN_W'(4);

   typedef logic [CNT_W-1:0] cnt_type;

   typedef enum logic [1:0] {
      ST_CHAR  = 2'd0,
      ST_END   = 2'd1,
      ST_TRUNC = 2'd2
   } status_type;

   typedef struct packed {
      logic [CP_W-1:0]      code_point;
      logic [OUT_CNT_W-1:0] byte_offset;
      logic [OUT_CNT_W-1:0] char_index;
      status_type           status;
   } result_type;

   typedef struct packed {
      logic       advance;
      logic [7:0] data_byte;
   } step_type;

   function automatic cnt_type sat_add(cnt_type a, logic [LEN_W-1:0] inc);
      logic [CNT_W:0] sum;
      sum = {1'b0, a} + (CNT_W+1)'(inc);
      if (sum[CNT_W]) begin
         return {CNT_W{1'b1}};
      end
      return sum[CNT_W-1:0];
   endfunction

   function automatic logic [OUT_CNT_W-1:0] to_out(cnt_type c);
      logic [CNT_EXT_W-1:0] ext;
      ext = CNT_EXT_W'(c);
      return ext[OUT_CNT_W-1:0];
   endfunction

endpackage

// ----- src/utf8d_core.sv -----
`include "utf8_code_point_decoder_assert.svh"

module utf8d_core (
   input  logic                 clock,
   input  logic                 reset,
   input  utf8d_pkg::step_type  step,
   output logic                 res_valid,
   output utf8d_pkg::result_type res
);

   logic [utf8d_pkg::PEND_W-1:0] pend_ff, pend_in;
   logic [utf8d_pkg::CP_W-1:0]   partial_ff, partial_in;
   logic [utf8d_pkg::LEN_W-1:0]  len_ff, len_in;
   utf8d_pkg::cnt_type           offset_ff, offset_in;
   utf8d_pkg::cnt_type           chars_ff, chars_in;

   logic [7:0]                   b;
   logic [utf8d_pkg::PEND_W-1:0] pend_dec;
   logic [utf8d_pkg::CP_W-1:0]   low6;
   logic [utf8d_pkg::CP_W-1:0]   cont_bits;
   logic [utf8d_pkg::CP_W-1:0]   merged;

   assign b        = step.data_byte;
   assign pend_dec = pend_ff - utf8d_pkg::PEND_W'(1);
   assign low6     = utf8d_pkg::CP_W'(b & utf8d_pkg::CONT_MASK);

   always_comb begin
      unique case (pend_dec)
         2'd0:    cont_bits = low6;
         2'd1:    cont_bits = low6 << 6;
         2'd2:    cont_bits = low6 << 12;
         default: cont_bits = low6 << 18;
      endcase
   end

   assign merged = partial_ff | cont_bits;

   // decode of the held byte; state only moves when step.advance is high
   always_comb begin
      res_valid      = 1'b0;
      res.code_point = '0;
      res.byte_offset = utf8d_pkg::to_out(offset_ff);
      res.char_index = utf8d_pkg::to_out(chars_ff);
      res.status     = utf8d_pkg::ST_CHAR;
      pend_in        = pend_ff;
      partial_in     = partial_ff;
      len_in         = len_ff;
      offset_in      = offset_ff;
      chars_in       = chars_ff;
      priority if (b == 8'h00) begin
         // end of string, or a sequence cut short
         res_valid  = 1'b1;
         res.status = (pend_ff != '0) ? utf8d_pkg::ST_TRUNC : utf8d_pkg::ST_END;
         pend_in    = '0;
         partial_in = '0;
         len_in     = '0;
         offset_in  = '0;
         chars_in   = '0;
      end else if (pend_ff == '0) begin
         if (!b[7]) begin
            res_valid      = 1'b1;
            res.code_point = utf8d_pkg::CP_W'(b);
            offset_in      = utf8d_pkg::sat_add(offset_ff, utf8d_pkg::LEN_ONE);
            chars_in       = utf8d_pkg::sat_add(chars_ff, utf8d_pkg::LEN_ONE);
         end else if (!b[5]) begin
            partial_in = utf8d_pkg::CP_W'(b & utf8d_pkg::LEAD2_MASK) << 6;
            len_in     = utf8d_pkg::LEN_TWO;
            pend_in    = 2'd1;
         end else if (!b[4]) begin
            partial_in = utf8d_pkg::CP_W'(b & utf8d_pkg::LEAD3_MASK) << 12;
            len_in     = utf8d_pkg::LEN_THREE;
            pend_in    = 2'd2;
         end else begin
            partial_in = utf8d_pkg::CP_W'(b & utf8d_pkg::LEAD4_MASK) << 18;
            len_in     = utf8d_pkg::LEN_FOUR;
            pend_in    = 2'd3;
         end
      end else if (pend_dec != '0) begin
         // more continuation words to come
         partial_in = merged;
         pend_in    = pend_dec;
      end else begin
         res_valid      = 1'b1;
         res.code_point = merged;
         offset_in      = utf8d_pkg::sat_add(offset_ff, len_ff);
         chars_in       = utf8d_pkg::sat_add(chars_ff, utf8d_pkg::LEN_ONE);
         partial_in     = '0;
         len_in         = '0;
         pend_in        = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff    <= '0;
         partial_ff <= '0;
         len_ff     <= '0;
         offset_ff  <= '0;
         chars_ff   <= '0;
      end else if (step.advance) begin
         pend_ff    <= pend_in;
         partial_ff <= partial_in;
         len_ff     <= len_in;
         offset_ff  <= offset_in;
         chars_ff   <= chars_in;
      end
   end

   `UTF8D_ASSERT_NOW(a_len_tracks_pending, clock, reset, pend_ff != '0,
      len_ff > utf8d_pkg::LEN_W'(pend_ff),
      "sequence length out of step with pending count")
   `UTF8D_ASSERT_NOW(a_idle_state_clean, clock, reset, pend_ff == '0,
      partial_ff == '0 && len_ff == '0, "leftover partial value between characters")
   `UTF8D_ASSERT_NEXT(a_nul_clears_counters, clock, reset,
      step.advance && step.data_byte == 8'h00,
      offset_ff == '0 && chars_ff == '0 && pend_ff == '0, "counters not cleared after nul")

endmodule

// ----- src/utf8_code_point_decoder.sv -----
// utf8 code point decoder
// input channel: req_valid / req_ready / req_data_byte, one byte of a
//   nul-terminated string per word
// result channel: rsp_valid / rsp_ready with rsp_code_point, rsp_byte_offset,
//   rsp_char_index and rsp_status (0 char, 1 end of string, 2 truncated)
// a lead byte of a multi-byte sequence gives no result; the result comes with
//   the last continuation byte, a nul byte always gives one
// a result reaches the rsp ports from the result register after its last byte
//   has passed the input register (decoded between the two registers)
// throughput: one byte per cycle while rsp_ready is high; the decode of one
//   byte is a single pass between the input and result registers
// stall: when rsp_ready is low the result register holds its word, and the
//   input register still takes one byte; bytes that give no result keep
//   flowing into the decoder
// reset: synchronous, clears both registers' valid flags and all decoder
//   state (pending count, partial value, offset and character counters)
`include "utf8_code_point_decoder_assert.svh"

module utf8_code_point_decoder (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [7:0]                        req_data_byte,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [utf8d_pkg::CP_W-1:0]        rsp_code_point,
   output logic [utf8d_pkg::OUT_CNT_W-1:0]   rsp_byte_offset,
   output logic [utf8d_pkg::OUT_CNT_W-1:0]   rsp_char_index,
   output logic [1:0]                        rsp_status
);

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff, in_byte_in;

   // result register
   logic                  out_valid_ff, out_valid_in;
   utf8d_pkg::result_type out_ff, out_in;

   utf8d_pkg::step_type   step;
   utf8d_pkg::result_type res;
   logic                  res_valid;
   logic                  advance;
   logic                  req_fire;

   // the held byte moves on when its result has room, or when it gives none
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready || !res_valid);
   assign req_ready = !in_valid_ff || advance;
   assign req_fire  = req_valid && req_ready;

   assign step.advance   = advance;
   assign step.data_byte = in_byte_ff;

   utf8d_core u_core (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .res_valid (res_valid),
      .res       (res)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_data_byte;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (advance && res_valid) begin
         out_valid_in = 1'b1;
         out_in       = res;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      out_ff     <= out_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_code_point  = out_ff.code_point;
   assign rsp_byte_offset = out_ff.byte_offset;
   assign rsp_char_index  = out_ff.char_index;
   assign rsp_status      = out_ff.status;

   // end and truncated words never carry a code point
   `UTF8D_ASSERT_NOW(a_marker_zero_cp, clock, reset,
      rsp_valid && out_ff.status != utf8d_pkg::ST_CHAR, rsp_code_point == '0,
      "end or truncated word with nonzero code point")
   // a stalled result must not be overwritten by a new one
   `UTF8D_ASSERT_NOW(a_no_overwrite, clock, reset,
      out_valid_ff && !rsp_ready && advance, !res_valid,
      "result register overwritten while stalled")

endmodule
